[rtl/erf_pkg.sv]
// Shared types and constants for the erf Maclaurin series block.
// Holds the sequencer state type, the multiplier request type and fixed-point constants.
// Depends on nothing.
package erf_pkg;

  localparam int XW = 16;
  localparam int YW = 32;
  localparam int TCW = 7;
  localparam int MW = 32;
  localparam int PW = 96;
  localparam int DVD_W = 68;
  localparam int TW = 64;
  localparam int SW = 66;

  localparam logic [TCW-1:0] TERM_RESET = 7'd100;
  localparam logic [16:0] X_LIMIT = 17'd16384;
  localparam logic [MW-1:0] TWO_OVER_SQRTPI = 32'd1211587906;
  localparam logic [YW-1:0] ONE_Q30 = 32'd1073741824;
  localparam logic signed [TW-1:0] ACC_LIMIT = 64'sh4000_0000_0000_0000;

  typedef enum logic [1:0] {
    MUL_LOAD,
    MUL_ADD_HI,
    MUL_ADD_SHR
  } mul_mode_t;

  typedef struct packed {
    logic      en;
    mul_mode_t mode;
    logic [MW-1:0] a;
    logic [MW-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_X2,
    S_LOOP,
    S_MUL_LO,
    S_MUL_HI,
    S_KDIV_GO,
    S_KDIV_WAIT,
    S_TDIV_GO,
    S_TDIV_WAIT,
    S_FIX,
    S_SC_LO,
    S_SC_HI,
    S_OUT
  } state_t;

endpackage

[rtl/erf_mul.sv]
// Shared 32 by 32 multiplier with a registered 96-bit product accumulator.
// Builds wide products by accumulating two partial products.
// Depends on erf_pkg.
module erf_mul
  import erf_pkg::*;
(
  input  logic          clk,
  input  mul_req_t      req,
  output logic [PW-1:0] prod
);

  logic [2*MW-1:0] pp;

  assign pp = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      unique case (req.mode)
        MUL_LOAD:    prod <= PW'(pp);
        MUL_ADD_HI:  prod <= prod + {pp, {MW{1'b0}}};
        MUL_ADD_SHR: prod <= PW'(pp) + (prod >> MW);
        default:     prod <= prod;
      endcase
    end
  end

endmodule

[rtl/erf_div.sv]
// Restoring unsigned divider that retires one quotient bit per cycle.
// Shared by the factor update and the term division of the series.
// Depends on nothing.
module erf_div #(
  parameter int DVD_W = 68,
  parameter int DIV_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff = trial - {1'b0, dsr};
  assign fits = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

endmodule

[rtl/erf_maclaurin_series.sv]
// Top level of the erf block: sequencer, accumulator, input and output registers.
// Uses erf_mul for all products and erf_div for all divisions.
// Depends on erf_pkg, erf_mul and erf_div.

// One word in gives one word out: erf(x) for a Q3.12 input, as Q1.30, saturated
// to plus or minus one, with a flag when |x| above 4 was clamped. The block takes
// one word at a time and is not ready while it works. Its pace is set by the
// bit-serial divider: the first series term takes one division and each further
// term two, a factor update and a term division. The number of terms comes from
// the configuration word, limited to MAX_TERMS, and resets to 100.
module erf_maclaurin_series
  import erf_pkg::*;
#(
  parameter int MAX_TERMS = 100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [XW-1:0]  x_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [YW-1:0]  erf_value,
  output logic                  input_clamped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TCW-1:0]        cfg_data
);

  localparam int KW = $clog2(MAX_TERMS + 1);
  localparam int DW = KW + 1;
  localparam logic signed [SW-1:0] ACC_MAX = SW'(ACC_LIMIT);
  localparam logic signed [SW-1:0] ACC_MIN = -ACC_MAX;
  localparam logic signed [YW-1:0] OUT_MAX = 32'sd1073741824;

  state_t state;
  state_t state_next;

  logic [TCW-1:0]       term_count;
  logic                 neg;
  logic                 clamped;
  logic [14:0]          xm;
  logic [28:0]          x2;
  logic [TW-1:0]        t;
  logic signed [TW-1:0] acc;
  logic [KW-1:0]        k;
  logic [KW-1:0]        n;
  logic [62:0]          mag;

  logic [16:0]          x_raw;
  logic [16:0]          x_abs;
  logic                 x_over;
  logic [14:0]          xm_in;
  logic [KW-1:0]        n_in;

  logic signed [SW-1:0] acc_ext;
  logic signed [SW-1:0] term_ext;
  logic signed [SW-1:0] acc_sum;
  logic signed [SW-1:0] acc_sat;
  logic [TW-1:0]        acc_abs;
  logic [30:0]          mag_q;
  logic [YW-1:0]        result;

  mul_req_t             mul_req;
  logic [PW-1:0]        prod;
  logic                 div_start;
  logic [DVD_W-1:0]     div_dividend;
  logic [DW-1:0]        div_divisor;
  logic                 div_done;
  logic [DVD_W-1:0]     div_quotient;

  erf_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  erf_div #(
    .DVD_W (DVD_W),
    .DIV_W (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign x_raw = {1'b0, x_value};
  assign x_abs = x_value[XW-1] ? (17'h10000 - x_raw) : x_raw;
  assign x_over = x_abs > X_LIMIT;
  assign xm_in = x_over ? X_LIMIT[14:0] : x_abs[14:0];

  always_comb begin
    if (int'(term_count) > MAX_TERMS) begin
      n_in = KW'(MAX_TERMS);
    end else begin
      n_in = KW'(term_count);
    end
  end

  assign acc_ext = {{(SW-TW){acc[TW-1]}}, acc};
  assign term_ext = {{(SW-TW){1'b0}}, div_quotient[TW-1:0]};
  assign acc_sum = k[0] ? (acc_ext - term_ext) : (acc_ext + term_ext);

  always_comb begin
    if (acc_sum > ACC_MAX) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < ACC_MIN) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum;
    end
  end

  assign acc_abs = acc[TW-1] ? (TW'(0) - acc) : acc;

  always_comb begin
    if (mag[62:41] != '0) begin
      mag_q = ONE_Q30[30:0];
    end else if (prod[40:8] > 33'(ONE_Q30)) begin
      mag_q = ONE_Q30[30:0];
    end else begin
      mag_q = prod[38:8];
    end
  end

  assign result = neg ? (YW'(0) - {1'b0, mag_q}) : {1'b0, mag_q};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_SQR;
      S_SQR:       state_next = S_X2;
      S_X2:        state_next = S_LOOP;
      S_LOOP: begin
        if (k == n) begin
          state_next = S_FIX;
        end else if (k == '0) begin
          state_next = S_TDIV_GO;
        end else begin
          state_next = S_MUL_LO;
        end
      end
      S_MUL_LO:    state_next = S_MUL_HI;
      S_MUL_HI:    state_next = S_KDIV_GO;
      S_KDIV_GO:   state_next = S_KDIV_WAIT;
      S_KDIV_WAIT: if (div_done) state_next = S_TDIV_GO;
      S_TDIV_GO:   state_next = S_TDIV_WAIT;
      S_TDIV_WAIT: if (div_done) state_next = S_LOOP;
      S_FIX:       state_next = S_SC_LO;
      S_SC_LO:     state_next = S_SC_HI;
      S_SC_HI:     state_next = S_OUT;
      S_OUT:       if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_req = '{en: 1'b0, mode: MUL_LOAD, a: '0, b: '0};
    div_start = 1'b0;
    div_dividend = {{(DVD_W-TW){1'b0}}, t};
    div_divisor = {k, 1'b1};
    unique case (state)
      S_SQR: begin
        mul_req = '{en: 1'b1, mode: MUL_LOAD, a: MW'(xm), b: MW'(xm)};
      end
      S_MUL_LO: begin
        mul_req = '{en: 1'b1, mode: MUL_LOAD, a: t[31:0], b: MW'(x2)};
      end
      S_MUL_HI: begin
        mul_req = '{en: 1'b1, mode: MUL_ADD_HI, a: t[63:32], b: MW'(x2)};
      end
      S_KDIV_GO: begin
        div_start = 1'b1;
        div_dividend = prod[91:24];
        div_divisor = DW'(k);
      end
      S_TDIV_GO: begin
        div_start = 1'b1;
      end
      S_SC_LO: begin
        mul_req = '{en: 1'b1, mode: MUL_LOAD, a: mag[31:0], b: TWO_OVER_SQRTPI};
      end
      S_SC_HI: begin
        mul_req = '{en: 1'b1, mode: MUL_ADD_SHR, a: MW'(mag[40:32]), b: TWO_OVER_SQRTPI};
      end
      default: begin
        mul_req = '{en: 1'b0, mode: MUL_LOAD, a: '0, b: '0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      term_count <= TERM_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        term_count <= cfg_data;
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          neg <= x_value[XW-1];
          clamped <= x_over;
          xm <= xm_in;
          n <= n_in;
          k <= '0;
          acc <= '0;
          t <= {{(TW-43){1'b0}}, xm_in, 28'd0};
        end
      end
      S_X2: x2 <= prod[28:0];
      S_KDIV_WAIT: begin
        if (div_done) begin
          t <= div_quotient[TW-1:0];
        end
      end
      S_TDIV_WAIT: begin
        if (div_done) begin
          acc <= acc_sat[TW-1:0];
          k <= k + 1'b1;
        end
      end
      S_FIX: begin
        neg <= neg ^ acc[TW-1];
        mag <= acc_abs[62:0];
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          erf_value <= result;
          input_clamped <= clamped;
        end
      end
      default: begin
      end
    endcase
  end

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (erf_value <= OUT_MAX && erf_value >= -OUT_MAX))
    else $error("Result word lies outside plus or minus one.");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> (acc <= ACC_LIMIT && acc >= -ACC_LIMIT))
    else $error("Accumulator left its saturation range.");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_KDIV_WAIT || state == S_TDIV_WAIT))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> (k <= n))
    else $error("Term index ran past the term count.");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("Result word appeared without a finished computation.");

endmodule

[tb/erf_checker.sv]
// Checker for erf_maclaurin_series: watches the input, result and configuration channels.
// Predicts erf(x) for each accepted word from the series and compares every result field.
// Depends on erf_pkg for port widths only.
module erf_checker
  import erf_pkg::*;
#(
  parameter int MAX_TERMS = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [XW-1:0] x_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [YW-1:0] erf_value,
  input  logic                 input_clamped,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [TCW-1:0]       cfg_data,
  output int                   failures,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [6:0]   TERMS_AT_RESET = 7'd100;
  localparam logic [16:0]  CLAMP_MAG = 17'd16384;
  localparam logic [63:0]  SERIES_SCALE = 64'd1211587906;
  localparam logic [63:0]  UNIT_Q30 = 64'd1073741824;
  localparam logic signed [63:0] SUM_LIMIT = 64'sh4000_0000_0000_0000;

  typedef struct {
    logic signed [YW-1:0] erf;
    logic                 clamp;
  } erf_result_t;

  erf_result_t erf_due[$];
  logic [6:0]  term_cnt;
  int          fail_cnt;

  function automatic erf_result_t erf_predict(logic [15:0] x, logic [6:0] terms);
    logic              neg;
    logic [16:0]       mag_x;
    logic              clamp;
    int unsigned       n;
    int unsigned       k;
    logic [63:0]       x2;
    logic [63:0]       factor;
    logic [63:0]       step_term;
    logic signed [63:0] sum;
    logic [127:0]      prod;
    logic [63:0]       mag;
    erf_result_t       r;
    neg = x[15];
    mag_x = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    clamp = 1'b0;
    if (mag_x > CLAMP_MAG) begin
      mag_x = CLAMP_MAG;
      clamp = 1'b1;
    end
    n = (terms > MAX_TERMS) ? MAX_TERMS : terms;
    x2 = 64'(mag_x) * 64'(mag_x);
    factor = 64'(mag_x) << 28;
    sum = 64'sd0;
    for (k = 0; k < n; k++) begin
      if (k > 0) begin
        prod = (128'(factor) * 128'(x2)) / (128'(k) << 24);
        factor = prod[63:0];
      end
      step_term = factor / 64'(2 * k + 1);
      if (k[0]) begin
        sum = sum - $signed(step_term);
      end else begin
        sum = sum + $signed(step_term);
      end
      if (sum > SUM_LIMIT) sum = SUM_LIMIT;
      if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
    end
    if (sum < 0) begin
      neg = !neg;
      mag = 64'(-sum);
    end else begin
      mag = 64'(sum);
    end
    if (mag >= (64'd1 << 41)) begin
      mag = UNIT_Q30;
    end else begin
      prod = 128'(mag) * 128'(SERIES_SCALE);
      mag = prod[103:40];
    end
    if (mag > UNIT_Q30) mag = UNIT_Q30;
    r.erf = neg ? -mag[31:0] : mag[31:0];
    r.clamp = clamp;
    return r;
  endfunction

  initial begin
    failures = 0;
    outstanding = 0;
    fail_cnt = 0;
    term_cnt = TERMS_AT_RESET;
  end

  always @(posedge clk) begin
    erf_result_t due;
    if (rst) begin
      erf_due.delete();
      term_cnt = TERMS_AT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) term_cnt = cfg_data;
      if (in_valid && in_ready) erf_due.push_back(erf_predict(x_value, term_cnt));
      if (out_valid && out_ready) begin
        if (erf_due.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected result word: expected none actual erf_value %0d clamp %0d",
                   $time, erf_value, input_clamped);
        end else begin
          due = erf_due.pop_front();
          if (erf_value !== due.erf) begin
            fail_cnt++;
            $display("%0t erf_value mismatch: expected %0d actual %0d",
                     $time, due.erf, erf_value);
          end
          if (input_clamped !== due.clamp) begin
            fail_cnt++;
            $display("%0t input_clamped mismatch: expected %0d actual %0d",
                     $time, due.clamp, input_clamped);
          end
        end
      end
    end
    failures <= fail_cnt;
    outstanding <= erf_due.size();
  end

endmodule

[tb/testbench.sv]
// Top of the erf_maclaurin_series testbench: clock, reset, stimulus and verdict.
// Instantiates the block beside erf_checker, which does all prediction and comparison.
// Depends on erf_pkg, erf_maclaurin_series and erf_checker.
module testbench
  import erf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 10000000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [XW-1:0] x_value;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [YW-1:0] erf_value;
  logic                 input_clamped;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TCW-1:0]       cfg_data;
  int                   failures;
  int                   outstanding;
  int                   cycle_cnt;
  bit                   no_idle;

  erf_maclaurin_series #(.MAX_TERMS(100)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .x_value(x_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .erf_value(erf_value), .input_clamped(input_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  erf_checker #(.MAX_TERMS(100)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .x_value(x_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .erf_value(erf_value), .input_clamped(input_clamped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    x_value = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_idle = 1'b0;
    cycle_cnt = 0;
  end

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
  end

  task automatic send_x(input logic [15:0] v);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    x_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_term_count(input logic [TCW-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_x();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      v = $urandom_range(0, 65535);
    end else if (sel < 60) begin
      v = $urandom_range(0, 4096);
    end else if (sel < 80) begin
      v = 16376 + $urandom_range(0, 16);
    end else if (sel < 90) begin
      case ($urandom_range(0, 2))
        0: v = 0;
        1: v = 32767;
        default: v = 32768;
      endcase
    end else begin
      v = $urandom_range(4096, 16384);
    end
    if (sel >= 35 && $urandom_range(0, 1) == 1) v = -v;
    return v[15:0];
  endfunction

  initial begin
    int          words;
    logic [6:0]  terms;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full series at the reset term count, over the extremes and the clamp boundary.
    send_x(16'sd0);
    send_x(16'sd32767);
    send_x(-16'sd32768);
    send_x(16'sd16384);
    send_x(-16'sd16384);
    send_x(16'sd16385);
    send_x(16'sd1);
    send_x(-16'sd1);

    // No terms at all gives zero.
    write_term_count(7'd0);
    send_x(16'sd32767);
    send_x(-16'sd5000);
    send_x(16'sd12345);

    // Counts above the term limit are capped.
    write_term_count(7'd127);
    send_x(16'sd8192);
    send_x(-16'sd16383);

    write_term_count(7'd1);
    send_x(16'sd4096);
    send_x(-16'sd32768);

    // Two terms leave a negative partial sum for large x.
    write_term_count(7'd2);
    send_x(16'sd16384);
    send_x(16'sd8000);
    send_x(-16'sd12000);

    for (int p = 0; p < 9; p++) begin
      words = 12;
      if (p == 3) begin
        terms = 7'($urandom_range(100, 127));
        words = 4;
      end else if (p == 5) begin
        terms = 7'd0;
      end else begin
        terms = 7'($urandom_range(1, 30));
      end
      write_term_count(terms);
      no_idle = (p == 6);
      for (int i = 0; i < words; i++) send_x(pick_x());
      drain_results();
      no_idle = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
